>>> rtl/separable_gaussian_blur_5tap_defines.svh
`ifndef SEPARABLE_GAUSSIAN_BLUR_5TAP_DEFINES_SVH
`define SEPARABLE_GAUSSIAN_BLUR_5TAP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SGB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sgb_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int AddrW     = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int ChanW     = 16;
  localparam int DimW      = 11;
  localparam int CoordW    = 10;
  localparam int AccW      = 35;
  localparam int NumTaps   = 5;
  localparam int NumChan   = 3;

  typedef logic [NumChan-1:0][ChanW-1:0] rgb_t;

  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CoordW-1:0] out_col;
    logic [CoordW-1:0] out_row;
    logic [ChanW-1:0]  red_out;
    logic [ChanW-1:0]  green_out;
    logic [ChanW-1:0]  blue_out;
    logic              run_last;
  } pix_out_t;

  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctrl_t;

  typedef enum logic [2:0] {
    REG_TAP0   = 3'd0,
    REG_TAP1   = 3'd1,
    REG_TAP2   = 3'd2,
    REG_TAP3   = 3'd3,
    REG_TAP4   = 3'd4,
    REG_WIDTH  = 3'd5,
    REG_HEIGHT = 3'd6
  } reg_idx_e;

  function automatic logic [ChanW-1:0] round_sat(input logic [AccW-1:0] acc);
    logic [AccW:0] s;
    s = {1'b0, acc} + (AccW+1)'(32768);
    if (|s[AccW:2*ChanW]) return {ChanW{1'b1}};
    return s[2*ChanW-1:ChanW];
  endfunction

endpackage
`default_nettype wire

>>> rtl/sgb_row_bank.sv
`timescale 1ns / 1ps
`default_nettype none
module sgb_row_bank (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic                re_i,
  input  wire logic [sgb_pkg::AddrW-1:0] addr_i,
  input  wire sgb_pkg::rgb_t       wdata_i,
  output sgb_pkg::rgb_t            rdata_o
);
  import sgb_pkg::*;

  rgb_t mem [MaxWidth];
  rgb_t rdata_q;

  // read-first and held: the old row stays visible for the whole request
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

>>> rtl/sgb_mac_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module sgb_mac_lane (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire sgb_pkg::mac_ctrl_t        ctrl_i,
  input  wire logic [sgb_pkg::ChanW-1:0] sample_i,
  input  wire logic [sgb_pkg::ChanW-1:0] tap_i,
  output logic [sgb_pkg::AccW-1:0]       acc_o
);
  import sgb_pkg::*;

  logic [2*ChanW-1:0] prod_q;
  logic               pv_q, clr_q;
  logic [AccW-1:0]    acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      clr_q <= 1'b0;
    end else begin
      pv_q  <= ctrl_i.en;
      clr_q <= ctrl_i.clr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= sample_i * tap_i;
    end
    if (pv_q) begin
      acc_q <= (clr_q ? '0 : acc_q) + AccW'(prod_q);
    end
  end

  assign acc_o = acc_q;
endmodule
`default_nettype wire

>>> rtl/separable_gaussian_blur_5tap.sv
// A new request is taken only once the last one is through: the three multiply-accumulate
// lanes run five taps for every pass in turn, and output stalls hold the block busy.
// Reset: position, taps, frame size and windows return to defaults; row stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "separable_gaussian_blur_5tap_defines.svh"
module separable_gaussian_blur_5tap (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire sgb_pkg::pix_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output sgb_pkg::pix_out_t      out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [sgb_pkg::ChanW-1:0] cfg_data_i
);
  import sgb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DCHK = 5'b00010,
    S_MAC  = 5'b00100,
    S_KCHK = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e            state_q;
  rgb_t              cur_q;
  logic [AddrW-1:0]  c_q, col_q;
  logic [RowW-1:0]   r_q, row_q;
  logic              lcol_q, lrow_q, ph_q, out_v_q;
  logic [1:0]        d_q, k_q;
  logic [2:0]        t_q;
  logic [ChanW-1:0]  taps_q [NumTaps];
  logic [DimW-1:0]   fw_q, fh_q;
  rgb_t              win_q [3][4];
  rgb_t              five_q [NumTaps];
  pix_out_t          out_q;

  logic [DimW-1:0]   w_eff, h_eff;
  logic              accept, cfg_we;
  rgb_t              in_rgb, vsample, vres, hres;
  rgb_t              bank_rd [4];
  logic [AccW-1:0]   acc [NumChan];
  logic [ChanW-1:0]  tap_sel;
  mac_ctrl_t         ctrl;
  logic [2:0]        tsel, hidx;
  logic [1:0]        kmax;
  logic              dv;
  logic signed [11:0] vr;
  logic [RowW-1:0]   rr;
  rgb_t              base [4];

  assign in_rgb[0] = in_data_i.red_in;
  assign in_rgb[1] = in_data_i.green_in;
  assign in_rgb[2] = in_data_i.blue_in;

  // hold requests while a register write waits, so writes fall between requests
  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    w_eff = (fw_q == '0) ? DimW'(1) : ((fw_q > DimW'(MaxWidth)) ? DimW'(MaxWidth) : fw_q);
    h_eff = (fh_q == '0) ? DimW'(1) : ((fh_q > DimW'(MaxHeight)) ? DimW'(MaxHeight) : fh_q);
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    sgb_row_bank u_bank (
      .clk_i   (clk_i),
      .we_i    (accept && (row_q[1:0] == 2'(b))),
      .re_i    (accept),
      .addr_i  (col_q),
      .wdata_i (in_rgb),
      .rdata_o (bank_rd[b])
    );
  end

  // clamped source row of the vertical tap
  always_comb begin
    vr = $signed({2'b00, r_q}) - $signed({10'b0, d_q}) + $signed({9'b0, t_q}) - 12'sd2;
    if (vr < 0) begin
      rr = '0;
    end else if (vr > $signed({1'b0, h_eff - DimW'(1)})) begin
      rr = RowW'(h_eff - DimW'(1));
    end else begin
      rr = vr[RowW-1:0];
    end
    vsample = (rr == r_q) ? cur_q : bank_rd[rr[1:0]];
  end

  assign tsel = (t_q < 3'(NumTaps)) ? t_q : 3'd0;
  assign tap_sel = taps_q[tsel];
  assign hidx = ({1'b0, tsel} + {2'b00, k_q} > 4'd4) ? 3'd4 : (tsel + {1'b0, k_q});
  assign ctrl.en  = (state_q == S_MAC) && (t_q < 3'(NumTaps));
  assign ctrl.clr = (t_q == 3'd0);

  for (genvar ch = 0; ch < NumChan; ch++) begin : g_lane
    sgb_mac_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .sample_i (ph_q ? five_q[hidx][ch] : vsample[ch]),
      .tap_i    (tap_sel),
      .acc_o    (acc[ch])
    );
    assign vres[ch] = round_sat(acc[ch]);
  end
  assign hres = vres;

  assign kmax = lcol_q ? 2'd2 : 2'd0;
  assign dv   = ((d_q == 2'd2) || lrow_q) && (r_q >= RowW'(d_q));

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      base[i] = (c_q == '0) ? vres : win_q[d_q][i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      out_v_q <= 1'b0;
      taps_q[0] <= ChanW'(3604);
      taps_q[1] <= ChanW'(16122);
      taps_q[2] <= ChanW'(26084);
      taps_q[3] <= ChanW'(16122);
      taps_q[4] <= ChanW'(3604);
      fw_q <= DimW'(640);
      fh_q <= DimW'(480);
      d_q  <= '0;
      k_q  <= '0;
      t_q  <= '0;
      ph_q <= 1'b0;
      for (int d = 0; d < 3; d++) begin
        for (int i = 0; i < 4; i++) begin
          win_q[d][i] <= '0;
        end
      end
    end else begin
      if ((state_q == S_EMIT) && (!out_v_q || !out_stall_i)) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (cfg_we) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_TAP0:   taps_q[0] <= cfg_data_i;
          REG_TAP1:   taps_q[1] <= cfg_data_i;
          REG_TAP2:   taps_q[2] <= cfg_data_i;
          REG_TAP3:   taps_q[3] <= cfg_data_i;
          REG_TAP4:   taps_q[4] <= cfg_data_i;
          REG_WIDTH: begin
            fw_q  <= cfg_data_i[DimW-1:0];
            col_q <= '0;
            row_q <= '0;
          end
          REG_HEIGHT: begin
            fh_q  <= cfg_data_i[DimW-1:0];
            col_q <= '0;
            row_q <= '0;
          end
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            d_q <= 2'd2;
            state_q <= S_DCHK;
            if ({1'b0, col_q} + DimW'(1) >= w_eff) begin
              col_q <= '0;
              row_q <= ({1'b0, row_q} + DimW'(1) >= h_eff) ? '0 : row_q + RowW'(1);
            end else begin
              col_q <= col_q + AddrW'(1);
            end
          end
        end
        S_DCHK: begin
          if (dv) begin
            ph_q <= 1'b0;
            t_q  <= '0;
            state_q <= S_MAC;
          end else if (d_q == 2'd0) begin
            state_q <= S_IDLE;
          end else begin
            d_q <= d_q - 2'd1;
          end
        end
        S_MAC: begin
          if (t_q == 3'd6) begin
            if (!ph_q) begin
              for (int i = 0; i < 4; i++) begin
                five_q[i] <= base[i];
              end
              five_q[4] <= vres;
              for (int i = 0; i < 3; i++) begin
                win_q[d_q][i] <= base[i+1];
              end
              win_q[d_q][3] <= vres;
              k_q <= '0;
              state_q <= S_KCHK;
            end else begin
              state_q <= S_EMIT;
            end
          end else begin
            t_q <= t_q + 3'd1;
          end
        end
        S_KCHK: begin
          if (k_q > kmax) begin
            if (d_q == 2'd0) begin
              state_q <= S_IDLE;
            end else begin
              d_q <= d_q - 2'd1;
              state_q <= S_DCHK;
            end
          end else if ({1'b0, c_q} + {9'b0, k_q} >= DimW'(2)) begin
            ph_q <= 1'b1;
            t_q  <= '0;
            state_q <= S_MAC;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        S_EMIT: begin
          if (!out_v_q || !out_stall_i) begin
            k_q <= k_q + 2'd1;
            state_q <= S_KCHK;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q  <= in_rgb;
      c_q    <= col_q;
      r_q    <= row_q;
      lcol_q <= ({1'b0, col_q} == w_eff - DimW'(1));
      lrow_q <= ({1'b0, row_q} == h_eff - DimW'(1));
    end
    if ((state_q == S_EMIT) && (!out_v_q || !out_stall_i)) begin
      out_q.out_col   <= CoordW'(c_q + AddrW'(k_q) - AddrW'(2));
      out_q.out_row   <= CoordW'(r_q - RowW'(d_q));
      out_q.red_out   <= hres[0];
      out_q.green_out <= hres[1];
      out_q.blue_out  <= hres[2];
      out_q.run_last  <= (k_q == kmax) && !(lrow_q && (d_q != 2'd0));
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `SGB_ASSERT_NEXT(a_accept_busy, accept, in_stall_o, "request accepted but block not busy")
  `SGB_ASSERT_NOW(a_col_range, 1'b1, ({1'b0, col_q} < w_eff), "column beyond frame width")
  `SGB_ASSERT_NOW(a_row_range, 1'b1, ({1'b0, row_q} < h_eff), "row beyond frame height")
  `SGB_ASSERT_NOW(a_emit_k, state_q == S_EMIT, (k_q <= kmax), "result beyond row end")
endmodule
`default_nettype wire
